[hdl/rtcdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rtcdc_pkg;

    localparam int unsigned SECS_PER_HOUR      = 3600;
    localparam int unsigned SECS_PER_MIN       = 60;
    localparam int unsigned SECS_PER_DAY       = 86400;
    localparam int unsigned DAYS_PER_YEAR      = 365;
    localparam int unsigned FIRST_HOUR         = 1;
    localparam int unsigned LAST_HOUR          = 16;
    localparam int unsigned MIN_INTERVAL_RESET = 20;

    // Reciprocal constants: floor(x * RECIP >> SHIFT) == floor(x / d) over the used range.
    // Divide by 10: exact for x < 81920.
    localparam logic [15:0] RECIP_10          = 16'd52429;
    localparam int unsigned RECIP_10_SHIFT    = 19;
    // Divide by 3600: exact for x < 86400.
    localparam logic [17:0] RECIP_3600        = 18'd149131;
    localparam int unsigned RECIP_3600_SHIFT  = 29;
    // Divide by 60: exact for x < 3600.
    localparam logic [11:0] RECIP_60          = 12'd2185;
    localparam int unsigned RECIP_60_SHIFT    = 17;

    typedef logic [16:0] secs_t;

    // Side data that rides along with every beat through the pipeline.
    typedef struct packed {
        logic       corrected;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [8:0] last_day;
    } meta_t;

    typedef enum logic [1:0] {
        CFG_DRIFT        = 2'd0,
        CFG_MIN_INTERVAL = 2'd1
    } cfg_idx_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[hdl/rtcdc_sec_split.sv]
`timescale 1ns / 1ps
`default_nettype none

// Split seconds of the day into hour, minute, second over four registered stages.
module rtcdc_sec_split
    import rtcdc_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         in_valid,
    output logic        in_ready,
    input  secs_t       in_secs,
    input  meta_t       in_meta,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [4:0]  out_hour,
    output logic [5:0]  out_minute,
    output logic [5:0]  out_second,
    output meta_t       out_meta
);

    logic        a_valid_reg, b_valid_reg, c_valid_reg, o_valid_reg;
    logic        en_a, en_b, en_c, en_o;

    logic [4:0]  a_hour_reg;
    secs_t       a_secs_reg;
    meta_t       a_meta_reg;
    logic [4:0]  b_hour_reg;
    logic [11:0] b_rem_reg;
    meta_t       b_meta_reg;
    logic [4:0]  c_hour_reg;
    logic [11:0] c_rem_reg;
    logic [5:0]  c_min_reg;
    meta_t       c_meta_reg;
    logic [4:0]  o_hour_reg;
    logic [5:0]  o_min_reg;
    logic [5:0]  o_sec_reg;
    meta_t       o_meta_reg;

    logic [34:0] hour_prod;
    logic [4:0]  hour_next;
    logic [16:0] rem_wide;
    logic [23:0] min_prod;
    logic [5:0]  min_next;
    logic [11:0] sec_wide;
    logic [5:0]  sec_next;

    assign en_o     = !o_valid_reg || out_ready;
    assign en_c     = !c_valid_reg || en_o;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    always_comb begin
        hour_prod = 35'(in_secs) * 35'(RECIP_3600);
        hour_next = hour_prod[RECIP_3600_SHIFT +: 5];
        rem_wide  = a_secs_reg - 17'(a_hour_reg) * 17'(SECS_PER_HOUR);
        min_prod  = 24'(b_rem_reg) * 24'(RECIP_60);
        min_next  = min_prod[RECIP_60_SHIFT +: 6];
        sec_wide  = c_rem_reg - 12'(c_min_reg) * 12'(SECS_PER_MIN);
        sec_next  = sec_wide[5:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (en_a) a_valid_reg <= in_valid;
            if (en_b) b_valid_reg <= a_valid_reg;
            if (en_c) c_valid_reg <= b_valid_reg;
            if (en_o) o_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_hour_reg <= hour_next;
            a_secs_reg <= in_secs;
            a_meta_reg <= in_meta;
        end
        if (en_b) begin
            b_hour_reg <= a_hour_reg;
            b_rem_reg  <= rem_wide[11:0];
            b_meta_reg <= a_meta_reg;
        end
        if (en_c) begin
            c_hour_reg <= b_hour_reg;
            c_rem_reg  <= b_rem_reg;
            c_min_reg  <= min_next;
            c_meta_reg <= b_meta_reg;
        end
        if (en_o) begin
            // pass the reading through untouched when no correction applies
            o_hour_reg <= c_meta_reg.corrected ? c_hour_reg : c_meta_reg.hour;
            o_min_reg  <= c_meta_reg.corrected ? c_min_reg  : c_meta_reg.minute;
            o_sec_reg  <= c_meta_reg.corrected ? sec_next   : c_meta_reg.second;
            o_meta_reg <= c_meta_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_hour   = o_hour_reg;
    assign out_minute = o_min_reg;
    assign out_second = o_sec_reg;
    assign out_meta   = o_meta_reg;

endmodule

`default_nettype wire

[hdl/rtc_drift_correction.sv]
`timescale 1ns / 1ps
`default_nettype none

// Clock drift correction. Each input beat carries one clock reading; each output beat
// carries the reading to write back, with m_tuser high when a correction was applied.
// The block forms the day of the year (leap day after February in years divisible by
// four), the days since the last correction (wrapping by 365), and, when enough days
// have passed and the hour is 1 to 16, shifts the time of day by drift * days / 10
// seconds, clamped to the same day. Rate: one beat per cycle, sustained while m_tready
// stays high. The seven-stage pipeline (input register, correction stage, clamp stage,
// three division stages and the output register) carries each beat in that order; the
// only loop is the stored correction day, which is read and written in the first stage,
// so back-to-back readings see each other's updates. Write drift_per_day (index 0) and
// min_interval_days (index 1) only while no beat is in flight.
module rtc_drift_correction
    import rtcdc_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_addr,
    input  wire  [8:0]  cfg_wdata,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    // [6:0] year_two_digit, [10:7] month_num, [15:11] day_of_month,
    // [20:16] hour_in, [26:21] minute_in, [32:27] second_in
    input  wire  [39:0] s_tdata,
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    // [4:0] hour_out, [10:5] minute_out, [16:11] second_out, [25:17] last_corr_day
    output logic [31:0] m_tdata,
    // [0] corrected
    output logic [0:0]  m_tuser
);

    // configuration registers
    logic signed [7:0] drift_reg;
    logic [8:0]        min_interval_reg;

    // day of the most recent correction
    logic [8:0]        last_day_reg;

    // stage 1: captured reading
    logic              v1_reg;
    logic [6:0]        s1_year_reg;
    logic [3:0]        s1_month_reg;
    logic [4:0]        s1_day_reg;
    logic [4:0]        s1_hour_reg;
    logic [5:0]        s1_min_reg;
    logic [5:0]        s1_sec_reg;

    // stage 2: product magnitude, sign and seconds of day
    logic              v2_reg;
    logic              s2_neg_reg;
    logic [15:0]       s2_mag_reg;
    secs_t             s2_secsum_reg;
    meta_t             s2_meta_reg;

    // stage 3: clamped seconds of day
    logic              v3_reg;
    secs_t             s3_secs_reg;
    meta_t             s3_meta_reg;

    logic              en1, en2, en3;
    logic              split_ready;

    logic [8:0]         today;
    logic               leap;
    logic signed [10:0] delta_raw;
    logic signed [10:0] delta;
    logic               fix;
    logic signed [18:0] prod;
    logic [18:0]        prod_abs;
    secs_t              secsum;
    meta_t              s1_meta;

    logic [31:0]        quot_prod;
    logic [12:0]        quot;
    logic signed [17:0] sum;
    secs_t              secs_next;

    logic               out_valid;
    logic [4:0]         out_hour;
    logic [5:0]         out_minute;
    logic [5:0]         out_second;
    meta_t              out_meta;

    // advance each stage when its successor has room
    assign en3      = !v3_reg || split_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // configuration writes; ignore indexes beyond the register list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drift_reg        <= 8'sd0;
            min_interval_reg <= 9'(MIN_INTERVAL_RESET);
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DRIFT:        drift_reg        <= $signed(cfg_wdata[7:0]);
                CFG_MIN_INTERVAL: min_interval_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // stage 1 logic: day of year, elapsed days, decision, drift product, seconds of day
    always_comb begin
        leap      = (s1_month_reg > 4'd2) && (s1_year_reg[1:0] == 2'b00);
        today     = days_before_month(s1_month_reg) + 9'(s1_day_reg) + 9'(leap);
        delta_raw = $signed({2'b00, today}) - $signed({2'b00, last_day_reg});
        delta     = delta_raw[10] ? delta_raw + 11'(DAYS_PER_YEAR) : delta_raw;
        fix       = (delta >= $signed({2'b00, min_interval_reg}))
                    && (s1_hour_reg >= 5'(FIRST_HOUR))
                    && (s1_hour_reg <= 5'(LAST_HOUR));
        prod      = 19'(drift_reg) * 19'(delta);
        prod_abs  = prod[18] ? 19'(-prod) : 19'(prod);
        secsum    = 17'(s1_hour_reg) * 17'(SECS_PER_HOUR)
                    + 17'(s1_min_reg) * 17'(SECS_PER_MIN)
                    + 17'(s1_sec_reg);

        s1_meta.corrected = fix;
        s1_meta.hour      = s1_hour_reg;
        s1_meta.minute    = s1_min_reg;
        s1_meta.second    = s1_sec_reg;
        s1_meta.last_day  = fix ? today : last_day_reg;
    end

    // stage 2 logic: divide by ten toward zero, apply, clamp to one day
    always_comb begin
        quot_prod = 32'(s2_mag_reg) * 32'(RECIP_10);
        quot      = quot_prod[RECIP_10_SHIFT +: 13];
        if (s2_neg_reg) begin
            sum = $signed({1'b0, s2_secsum_reg}) - $signed({5'b00000, quot});
        end else begin
            sum = $signed({1'b0, s2_secsum_reg}) + $signed({5'b00000, quot});
        end
        if (sum[17]) begin
            secs_next = '0;
        end else if (sum > $signed(18'(SECS_PER_DAY - 1))) begin
            secs_next = 17'(SECS_PER_DAY - 1);
        end else begin
            secs_next = sum[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            last_day_reg <= '0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            // record the day as the beat leaves stage 1, so the next reading sees it
            if (v1_reg && en2 && fix) last_day_reg <= today;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_year_reg  <= s_tdata[6:0];
            s1_month_reg <= s_tdata[10:7];
            s1_day_reg   <= s_tdata[15:11];
            s1_hour_reg  <= s_tdata[20:16];
            s1_min_reg   <= s_tdata[26:21];
            s1_sec_reg   <= s_tdata[32:27];
        end
        if (en2) begin
            s2_neg_reg    <= prod[18];
            s2_mag_reg    <= prod_abs[15:0];
            s2_secsum_reg <= secsum;
            s2_meta_reg   <= s1_meta;
        end
        if (en3) begin
            s3_secs_reg <= secs_next;
            s3_meta_reg <= s2_meta_reg;
        end
    end

    rtcdc_sec_split u_split (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v3_reg),
        .in_ready   (split_ready),
        .in_secs    (s3_secs_reg),
        .in_meta    (s3_meta_reg),
        .out_valid  (out_valid),
        .out_ready  (m_tready),
        .out_hour   (out_hour),
        .out_minute (out_minute),
        .out_second (out_second),
        .out_meta   (out_meta)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {6'b000000, out_meta.last_day, out_second, out_minute, out_hour};
    assign m_tuser  = out_meta.corrected;

    // a correction leaving stage 1 must land in the stored day
    a_last_day_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && en2 && fix) |=> (last_day_reg == $past(today)))
        else $error("stored correction day not updated");

    // the stored day never exceeds the longest year
    a_last_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        last_day_reg <= 9'd366)
        else $error("stored correction day out of range");

    // a corrected time is always a valid time of day
    a_corrected_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[4:0] <= 5'd23) && (m_tdata[10:5] <= 6'd59) && (m_tdata[16:11] <= 6'd59))
        else $error("corrected time out of range");

endmodule

`default_nettype wire

[sim/rtc_drift_correction_test.sv]
`timescale 1ns / 1ps

module rtc_drift_correction_test
    import rtcdc_pkg::*;
();

    localparam int DRIFT_DIVISOR   = 10;
    localparam int CYCLE_LIMIT     = 200_000;
    localparam int TAIL_CYCLES     = 16;
    localparam int PHASES          = 8;
    localparam int PHASE_READINGS  = 130;
    localparam int PLAN_ROWS       = 27;
    // Register indexes with no register behind them: writes there must do nothing.
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } reading_t;

    typedef struct packed {
        logic       corrected;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [8:0] last_day;
    } writeback_t;

    typedef enum logic { ROW_WRITE, ROW_READING } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [1:0] addr;
        logic [8:0] wdata;
        reading_t   rd;
        bit         typed;
        writeback_t want;
    } plan_row_t;

    localparam reading_t   NO_READING = '0;
    localparam writeback_t NO_WB      = '0;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [8:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    // Our copy of the block's state and registers.
    logic signed [7:0] drift_setting;
    logic [8:0]        min_days;
    logic [8:0]        corr_day;
    int unsigned       month_offset [16];

    writeback_t pending_writebacks [$];
    int         errors = 0;
    int         cycles = 0;
    bit         quiet;      // no idling on either side while set
    plan_row_t  plan [PLAN_ROWS];

    rtc_drift_correction DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic reading_t clock_at(input int y, input int mo, input int d,
                                          input int h, input int mi, input int s);
        reading_t r;
        r.year   = y[6:0];
        r.month  = mo[3:0];
        r.day    = d[4:0];
        r.hour   = h[4:0];
        r.minute = mi[5:0];
        r.second = s[5:0];
        return r;
    endfunction

    function automatic writeback_t wb(input int c, input int h, input int mi, input int s,
                                      input int l);
        writeback_t w;
        w.corrected = c[0];
        w.hour      = h[4:0];
        w.minute    = mi[5:0];
        w.second    = s[5:0];
        w.last_day  = l[8:0];
        return w;
    endfunction

    // Work out the write-back for one reading and advance the stored correction day.
    function automatic writeback_t corrected_time_of(input reading_t r);
        int         today;
        int         delta;
        int         secs;
        int         drift;
        writeback_t w;
        today = int'(month_offset[r.month]) + int'(r.day);
        // leap day after February in years divisible by four
        if (r.month > 4'd2 && r.year[1:0] == 2'b00)
            today++;
        delta = today - int'(corr_day);
        if (delta < 0)
            delta += int'(DAYS_PER_YEAR);
        w = {1'b0, r.hour, r.minute, r.second, corr_day};
        if (delta >= int'(min_days) && r.hour >= FIRST_HOUR && r.hour <= LAST_HOUR) begin
            drift = int'(drift_setting);
            secs  = int'(r.hour) * int'(SECS_PER_HOUR) + int'(r.minute) * int'(SECS_PER_MIN)
                    + int'(r.second);
            // signed int division truncates toward zero
            secs += (drift * delta) / DRIFT_DIVISOR;
            if (secs < 0)
                secs = 0;
            if (secs > int'(SECS_PER_DAY) - 1)
                secs = int'(SECS_PER_DAY) - 1;
            corr_day    = today[8:0];
            w.corrected = 1'b1;
            w.hour      = 5'(secs / int'(SECS_PER_HOUR));
            w.minute    = 6'((secs % int'(SECS_PER_HOUR)) / int'(SECS_PER_MIN));
            w.second    = 6'(secs % int'(SECS_PER_MIN));
            w.last_day  = corr_day;
        end
        return w;
    endfunction

    // Mostly plausible readings with hours biased into the correction window,
    // the rest raw bits so every field bit toggles.
    function automatic reading_t random_reading();
        reading_t    r;
        logic [63:0] raw;
        if ($urandom_range(99) < 20) begin
            raw = {$urandom(), $urandom()};
            r   = raw[32:0];
        end else begin
            r.year   = 7'($urandom_range(99));
            r.month  = 4'($urandom_range(12, 1));
            r.day    = 5'($urandom_range(31, 1));
            r.hour   = ($urandom_range(99) < 75) ? 5'($urandom_range(16, 1))
                                                 : 5'($urandom_range(23));
            r.minute = 6'($urandom_range(59));
            r.second = 6'($urandom_range(59));
        end
        return r;
    endfunction

    // Write one register; only called with nothing in flight.
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DRIFT:        drift_setting = val[7:0];
            CFG_MIN_INTERVAL: min_days      = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid and hold until every write-back has come out.
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_writebacks.size() != 0);
    endtask

    // Offer one reading, wait for the beat, then record what must come back.
    task automatic send_reading(input reading_t r, input bit typed, input writeback_t want);
        writeback_t predicted;
        if (!quiet) begin
            while ($urandom_range(99) < 9) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.second, r.minute, r.hour, r.day, r.month, r.year};
        do @(posedge aclk); while (!s_tready);
        predicted = corrected_time_of(r);
        pending_writebacks.push_back(typed ? want : predicted);
    endtask

    // Result side: random back-pressure, and compare each beat with the oldest entry.
    always @(posedge aclk) begin : check_writeback
        writeback_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 9);
            if (m_tvalid && m_tready) begin
                if (pending_writebacks.size() == 0) begin
                    $error("unexpected write-back beat: tdata %h tuser %b", m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = pending_writebacks.pop_front();
                    if (m_tuser[0] !== want.corrected) begin
                        $error("corrected: expected %0d, got %0d", want.corrected, m_tuser[0]);
                        errors++;
                    end
                    if (m_tdata[4:0] !== want.hour) begin
                        $error("hour_out: expected %0d, got %0d", want.hour, m_tdata[4:0]);
                        errors++;
                    end
                    if (m_tdata[10:5] !== want.minute) begin
                        $error("minute_out: expected %0d, got %0d", want.minute, m_tdata[10:5]);
                        errors++;
                    end
                    if (m_tdata[16:11] !== want.second) begin
                        $error("second_out: expected %0d, got %0d", want.second,
                               m_tdata[16:11]);
                        errors++;
                    end
                    if (m_tdata[25:17] !== want.last_day) begin
                        $error("last_corr_day: expected %0d, got %0d", want.last_day,
                               m_tdata[25:17]);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[rtc_drift_correction] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int        p;
        int        i;
        int        drift_val;
        int        min_val;
        logic      spare;
        plan_row_t row;

        quiet  = 1'b0;
        month_offset = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 0, 0, 0};
        drift_setting = '0;
        min_days      = 9'(MIN_INTERVAL_RESET);
        corr_day      = '0;

        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;

        // Directed plan. Typed expectations only where obvious; the rest is predicted.
        plan = '{
            // reset registers: drift 0, interval 20
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(0, 1, 1, 12, 0, 0), 1'b1,
              wb(0, 12, 0, 0, 0)},
            // every field at its top, hour outside the window
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(127, 15, 31, 31, 63, 63), 1'b1,
              wb(0, 31, 63, 63, 0)},
            // last day of a leap year, last hour of the window, zero drift
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(0, 12, 31, 16, 59, 59), 1'b1,
              wb(1, 16, 59, 59, 366)},
            // negative difference wraps to zero days
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(1, 1, 1, 1, 0, 0), 1'b1,
              wb(0, 1, 0, 0, 366)},
            // hour 0 and hour 17 sit outside the window
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(3, 6, 15, 0, 30, 30), 1'b1,
              wb(0, 0, 30, 30, 366)},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(3, 6, 15, 17, 0, 0), 1'b1,
              wb(0, 17, 0, 0, 366)},
            // top positive drift, zero interval
            '{ROW_WRITE, CFG_DRIFT, 9'h07F, NO_READING, 1'b0, NO_WB},
            '{ROW_WRITE, CFG_MIN_INTERVAL, 9'd0, NO_READING, 1'b0, NO_WB},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(0, 3, 1, 1, 0, 0), 1'b0, NO_WB},
            // month 0 adds no offset
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(4, 0, 5, 16, 59, 59), 1'b0, NO_WB},
            // most negative drift drives the time below midnight: clamp to zero
            '{ROW_WRITE, CFG_DRIFT, 9'h080, NO_READING, 1'b0, NO_WB},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(1, 12, 31, 1, 0, 0), 1'b1,
              wb(1, 0, 0, 0, 365)},
            // drift -1: quotients truncate toward zero; spare top data bit set
            '{ROW_WRITE, CFG_DRIFT, 9'h1FF, NO_READING, 1'b0, NO_WB},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(2, 1, 19, 10, 0, 0), 1'b0, NO_WB},
            // minute and second beyond 59 enter the sum
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(2, 2, 10, 2, 63, 63), 1'b0, NO_WB},
            // largest interval, then writes to spare indexes that must not land
            '{ROW_WRITE, CFG_MIN_INTERVAL, 9'h1FF, NO_READING, 1'b0, NO_WB},
            '{ROW_WRITE, CFG_SPARE_2, 9'h055, NO_READING, 1'b0, NO_WB},
            '{ROW_WRITE, CFG_SPARE_3, 9'd0, NO_READING, 1'b0, NO_WB},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(2, 2, 11, 5, 6, 7), 1'b1,
              wb(0, 5, 6, 7, 41)},
            // interval boundary: 19 days no, 20 days yes
            '{ROW_WRITE, CFG_MIN_INTERVAL, 9'd20, NO_READING, 1'b0, NO_WB},
            '{ROW_WRITE, CFG_DRIFT, 9'd10, NO_READING, 1'b0, NO_WB},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(2, 3, 1, 8, 0, 0), 1'b1,
              wb(0, 8, 0, 0, 41)},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(2, 3, 2, 8, 0, 0), 1'b1,
              wb(1, 8, 0, 20, 61)},
            // leap year: Feb 29 gets no extra day, Mar 1 does
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(96, 2, 29, 12, 0, 0), 1'b0, NO_WB},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(96, 3, 1, 12, 0, 0), 1'b1,
              wb(0, 12, 0, 0, 60)},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(0, 12, 31, 0, 0, 0), 1'b0, NO_WB},
            '{ROW_READING, CFG_DRIFT, 9'd0, clock_at(99, 7, 4, 16, 0, 0), 1'b0, NO_WB}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k]) begin
            row = plan[k];
            if (row.kind == ROW_WRITE) begin
                settle_pipeline();
                write_reg(row.addr, row.wdata);
            end else begin
                send_reading(row.rd, row.typed, row.want);
            end
        end

        // Random phases, each under its own register setting; extremes come first.
        for (p = 0; p < PHASES; p++) begin
            settle_pipeline();
            drift_val = $urandom_range(255) - 128;
            min_val   = $urandom_range(365, 1);
            case (p)
                0: begin drift_val = 127;  min_val = 1;   end
                1: begin drift_val = -128; min_val = 365; end
                2: min_val = 0;
                3: begin drift_val = -1;   min_val = 20;  end
                5: min_val = 511;
                6: drift_val = 1;
                default: ;
            endcase
            spare = 1'($urandom_range(1));
            write_reg(CFG_DRIFT, {spare, 8'(drift_val)});
            write_reg(CFG_MIN_INTERVAL, 9'(min_val));
            // hold both sides busy for two full phases
            quiet = (p == 2 || p == 3);
            for (i = 0; i < PHASE_READINGS; i++) begin
                if (p == 4 && i == PHASE_READINGS / 2)
                    settle_pipeline();
                send_reading(random_reading(), 1'b0, NO_WB);
            end
        end

        settle_pipeline();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_writebacks.size() == 0)
            $display("[rtc_drift_correction] OK");
        else
            $display("[rtc_drift_correction] ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/rtcdc_pkg.sv
hdl/rtcdc_sec_split.sv
hdl/rtc_drift_correction.sv
sim/rtc_drift_correction_test.sv
